/* rtl/gli_pkg.sv */
// Shared types and constants of the gap linear interpolator.
package gli_pkg;

  // Width of the sample ports.
  localparam int VALUE_W = 32;

  // Defaults of the top-level parameters.
  localparam int MAX_GAP_DEF      = 63;
  localparam int SAMPLE_WIDTH_DEF = 32;

  // Number of commands that fit between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Control part of one command passed from the front to the back.
  typedef struct packed {
    logic hold;     // emit a run of held values
    logic ovf;      // the run was flushed for exceeding the gap limit
    logic col_end;  // the request closes its column
    logic have;     // a known value preceded the run in this column
  } cmd_ctl_t;

endpackage

/* rtl/gli_front.sv */
// Front end: takes requests, tracks the column state and issues commands.
module gli_front #(
  parameter int SAMPLE_WIDTH = gli_pkg::SAMPLE_WIDTH_DEF,
  parameter int MAX_GAP      = gli_pkg::MAX_GAP_DEF,
  parameter int CNT_W        = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                    in_is_missing,
  input  logic                    in_column_end,
  input  logic                    q_full,
  output logic                    q_push,
  output gli_pkg::cmd_ctl_t       cmd_ctl,
  output logic [SAMPLE_WIDTH-1:0] cmd_a,
  output logic [SAMPLE_WIDTH-1:0] cmd_b,
  output logic [CNT_W-1:0]        cmd_count
);

  logic [SAMPLE_WIDTH-1:0] prev_r;
  logic                    have_r;
  logic [CNT_W-1:0]        pend_r;

  logic accept;
  logic ovf;
  logic wait_only;

  assign accept    = in_valid && !q_full;
  assign ovf       = (pend_r >= CNT_W'(MAX_GAP));
  // A missing sample inside a column only extends the pending run, unless the run has reached MAX_GAP.
  assign wait_only = in_is_missing && !ovf && !in_column_end;
  assign q_push    = accept && !wait_only;

  assign cmd_ctl.hold    = in_is_missing;
  assign cmd_ctl.ovf     = in_is_missing && ovf;
  assign cmd_ctl.col_end = in_column_end;
  assign cmd_ctl.have    = have_r;
  assign cmd_a           = have_r ? prev_r : '0;
  assign cmd_b           = in_sample;
  assign cmd_count       = in_is_missing ? pend_r + CNT_W'(1) : pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      have_r <= 1'b0;
      pend_r <= '0;
    end else if (accept) begin
      priority if (in_column_end) begin
        prev_r <= '0;
        have_r <= 1'b0;
        pend_r <= '0;
      end else if (wait_only) begin
        pend_r <= pend_r + CNT_W'(1);
      end else if (in_is_missing) begin
        pend_r <= '0;
      end else begin
        prev_r <= in_sample;
        have_r <= 1'b1;
        pend_r <= '0;
      end
    end
  end

endmodule

/* rtl/gli_queue.sv */
// Small register FIFO that decouples the front end from the back end.
module gli_queue #(
  parameter int W     = 8,
  parameter int DEPTH = gli_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

/* rtl/gli_back.sv */
// Back end: divides the gap step, then streams fills, held runs and samples.
module gli_back #(
  parameter int SAMPLE_WIDTH = gli_pkg::SAMPLE_WIDTH_DEF,
  parameter int CNT_W        = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  output logic                    q_pop,
  input  gli_pkg::cmd_ctl_t       cmd_ctl,
  input  logic [SAMPLE_WIDTH-1:0] cmd_a,
  input  logic [SAMPLE_WIDTH-1:0] cmd_b,
  input  logic [CNT_W-1:0]        cmd_count,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SAMPLE_WIDTH-1:0] out_value,
  output logic                    out_was_filled,
  output logic                    out_gap_overflow,
  output logic                    out_run_last,
  output logic                    out_column_done
);

  localparam int DW  = SAMPLE_WIDTH + 1;
  localparam int DCW = $clog2(DW + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ABS, ST_DIV, ST_PREP, ST_FILL, ST_HOLD, ST_LAST
  } state_t;

  state_t                  state_r;
  gli_pkg::cmd_ctl_t       ctl_r;
  logic [SAMPLE_WIDTH-1:0] a_r;
  logic [SAMPLE_WIDTH-1:0] b_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        den_r;
  logic [DW-1:0]           diff_r;
  logic                    neg_r;
  logic [DW-1:0]           quo_r;
  logic [CNT_W-1:0]        rem_r;
  logic [DCW-1:0]          div_cnt_r;
  logic [DW-1:0]           acc_q_r;
  logic [CNT_W-1:0]        acc_rem_r;

  logic                    out_valid_r;
  logic [SAMPLE_WIDTH-1:0] out_value_r;
  logic                    out_was_filled_r;
  logic                    out_gap_overflow_r;
  logic                    out_run_last_r;
  logic                    out_column_done_r;

  logic                    out_free;
  logic [DW-1:0]           diff_nxt;
  logic [DW-1:0]           mag;
  logic [CNT_W:0]          div_sh;
  logic                    div_ge;
  logic [CNT_W-1:0]        div_rem;
  logic [CNT_W:0]          adv_sum;
  logic                    adv_ge;
  logic [CNT_W-1:0]        adv_rem;
  logic [DW-1:0]           adv_q;
  logic [DW:0]             a_ext;
  logic [DW:0]             q_ext;
  logic [DW:0]             fill_sum;
  logic [SAMPLE_WIDTH-1:0] fill_val;
  logic                    hold_last;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;

  assign diff_nxt = {cmd_b[SAMPLE_WIDTH-1], cmd_b} - {cmd_a[SAMPLE_WIDTH-1], cmd_a};
  assign mag      = diff_r[DW-1] ? (~diff_r + DW'(1)) : diff_r;

  // One restoring step of |b - a| / (k + 1).
  assign div_sh  = {rem_r, quo_r[DW-1]};
  assign div_ge  = (div_sh >= {1'b0, den_r});
  assign div_rem = div_ge ? CNT_W'(div_sh - {1'b0, den_r}) : div_sh[CNT_W-1:0];

  // The accumulator holds |b - a| * j + den / 2 as quotient and remainder;
  // adding the step keeps the remainder below twice the divisor.
  assign adv_sum = {1'b0, acc_rem_r} + {1'b0, rem_r};
  assign adv_ge  = (adv_sum >= {1'b0, den_r});
  assign adv_rem = adv_ge ? CNT_W'(adv_sum - {1'b0, den_r}) : adv_sum[CNT_W-1:0];
  assign adv_q   = acc_q_r + quo_r + DW'(adv_ge);

  assign a_ext     = {a_r[SAMPLE_WIDTH-1], a_r[SAMPLE_WIDTH-1], a_r};
  assign q_ext     = {1'b0, acc_q_r};
  assign fill_sum  = neg_r ? (a_ext - q_ext) : (a_ext + q_ext);
  assign fill_val  = ctl_r.have ? fill_sum[SAMPLE_WIDTH-1:0] : b_r;
  assign hold_last = (cnt_r == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            ctl_r  <= cmd_ctl;
            a_r    <= cmd_a;
            b_r    <= cmd_b;
            cnt_r  <= cmd_count;
            den_r  <= cmd_count + CNT_W'(1);
            diff_r <= diff_nxt;
            priority if (cmd_ctl.hold) begin
              state_r <= ST_HOLD;
            end else if (cmd_count == '0) begin
              state_r <= ST_LAST;
            end else if (cmd_ctl.have) begin
              state_r <= ST_ABS;
            end else begin
              state_r <= ST_FILL;
            end
          end
        end
        ST_ABS: begin
          neg_r     <= diff_r[DW-1];
          quo_r     <= mag;
          rem_r     <= '0;
          div_cnt_r <= DCW'(DW);
          acc_q_r   <= '0;
          acc_rem_r <= den_r >> 1;
          state_r   <= ST_DIV;
        end
        ST_DIV: begin
          rem_r     <= div_rem;
          quo_r     <= {quo_r[DW-2:0], div_ge};
          div_cnt_r <= div_cnt_r - DCW'(1);
          if (div_cnt_r == DCW'(1)) begin
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          acc_q_r   <= adv_q;
          acc_rem_r <= adv_rem;
          state_r   <= ST_FILL;
        end
        ST_FILL: begin
          if (out_free) begin
            out_valid_r        <= 1'b1;
            out_value_r        <= fill_val;
            out_was_filled_r   <= 1'b1;
            out_gap_overflow_r <= 1'b0;
            out_run_last_r     <= 1'b0;
            out_column_done_r  <= 1'b0;
            acc_q_r            <= adv_q;
            acc_rem_r          <= adv_rem;
            cnt_r              <= cnt_r - CNT_W'(1);
            if (hold_last) begin
              state_r <= ST_LAST;
            end
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_valid_r        <= 1'b1;
            out_value_r        <= a_r;
            out_was_filled_r   <= 1'b1;
            out_gap_overflow_r <= ctl_r.ovf;
            out_run_last_r     <= hold_last;
            out_column_done_r  <= hold_last && ctl_r.col_end;
            cnt_r              <= cnt_r - CNT_W'(1);
            if (hold_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_LAST: begin
          if (out_free) begin
            out_valid_r        <= 1'b1;
            out_value_r        <= b_r;
            out_was_filled_r   <= 1'b0;
            out_gap_overflow_r <= 1'b0;
            out_run_last_r     <= 1'b1;
            out_column_done_r  <= ctl_r.col_end;
            state_r            <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_value        = out_value_r;
  assign out_was_filled   = out_was_filled_r;
  assign out_gap_overflow = out_gap_overflow_r;
  assign out_run_last     = out_run_last_r;
  assign out_column_done  = out_column_done_r;

endmodule

/* rtl/gap_linear_interpolator_top.sv */
// Top level of the gap linear interpolator: front end, command queue, back end.
//
//   Channel  Direction  Handshake            Payload
//   in_      request    in_valid / in_stall  sample_value, is_missing, column_end
//   out_     result     out_valid/out_stall  value, was_filled, gap_overflow,
//                                            run_last, column_done
//
// A missing sample inside a run produces nothing until the run reaches MAX_GAP.
// A known sample with no pending gap passes through, and a held run of n values emits
// n held values; a gap of k after a known value first runs the bit-serial divider that
// finds the fill step, then emits the k fills and the sample.
// Reset is synchronous and active low and clears the column state, queue and FSM.
// A two-entry queue lets the front keep taking requests while the back waits on out_stall.
module gap_linear_interpolator_top #(
  parameter int MAX_GAP      = gli_pkg::MAX_GAP_DEF,
  parameter int SAMPLE_WIDTH = gli_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [gli_pkg::VALUE_W-1:0] in_sample_value,
  input  logic                        in_is_missing,
  input  logic                        in_column_end,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gli_pkg::VALUE_W-1:0] out_value,
  output logic                        out_was_filled,
  output logic                        out_gap_overflow,
  output logic                        out_run_last,
  output logic                        out_column_done
);

  localparam int CNT_W = $clog2(MAX_GAP + 2);
  localparam int QW    = $bits(gli_pkg::cmd_ctl_t) + 2 * SAMPLE_WIDTH + CNT_W;

  logic [SAMPLE_WIDTH-1:0] sample;
  logic [SAMPLE_WIDTH-1:0] back_value;

  logic                    q_push;
  logic                    q_pop;
  logic                    q_full;
  logic                    q_empty;
  logic [QW-1:0]           q_wdata;
  logic [QW-1:0]           q_rdata;

  gli_pkg::cmd_ctl_t       f_ctl;
  logic [SAMPLE_WIDTH-1:0] f_a;
  logic [SAMPLE_WIDTH-1:0] f_b;
  logic [CNT_W-1:0]        f_count;
  gli_pkg::cmd_ctl_t       h_ctl;
  logic [SAMPLE_WIDTH-1:0] h_a;
  logic [SAMPLE_WIDTH-1:0] h_b;
  logic [CNT_W-1:0]        h_count;

  // Samples are used at SAMPLE_WIDTH bits as two's complement.
  if (SAMPLE_WIDTH <= gli_pkg::VALUE_W) begin : g_in_narrow
    assign sample = in_sample_value[SAMPLE_WIDTH-1:0];
  end else begin : g_in_wide
    assign sample = {{(SAMPLE_WIDTH - gli_pkg::VALUE_W){1'b0}}, in_sample_value};
  end

  if (SAMPLE_WIDTH >= gli_pkg::VALUE_W) begin : g_out_wide
    assign out_value = back_value[gli_pkg::VALUE_W-1:0];
  end else begin : g_out_narrow
    assign out_value = {{(gli_pkg::VALUE_W - SAMPLE_WIDTH){1'b0}}, back_value};
  end

  assign in_stall = q_full;
  assign q_wdata  = {f_ctl, f_a, f_b, f_count};
  assign {h_ctl, h_a, h_b, h_count} = q_rdata;

  gli_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .MAX_GAP      (MAX_GAP),
    .CNT_W        (CNT_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_sample     (sample),
    .in_is_missing (in_is_missing),
    .in_column_end (in_column_end),
    .q_full        (q_full),
    .q_push        (q_push),
    .cmd_ctl       (f_ctl),
    .cmd_a         (f_a),
    .cmd_b         (f_b),
    .cmd_count     (f_count)
  );

  gli_queue #(
    .W     (QW),
    .DEPTH (gli_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  gli_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .CNT_W        (CNT_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .cmd_ctl          (h_ctl),
    .cmd_a            (h_a),
    .cmd_b            (h_b),
    .cmd_count        (h_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value        (back_value),
    .out_was_filled   (out_was_filled),
    .out_gap_overflow (out_gap_overflow),
    .out_run_last     (out_run_last),
    .out_column_done  (out_column_done)
  );

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("command pushed into a full queue");
  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("command popped from an empty queue");
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_column_done) |-> out_run_last)
    else $error("column end on a result that does not close its request");
  a_ovf_filled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_gap_overflow) |-> out_was_filled)
    else $error("overflow flag on a passed-through sample");
`endif

endmodule
